### src/sqltok_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the SQL comment and string tokenizer.
// No dependencies.
package sqltok_pkg;

   localparam int POSITION_BITS = 16;
   localparam int POS_W         = POSITION_BITS + 1;
   localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_UNIT  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [2:0] OPEN_NONE  = 3'd0;
   localparam logic [2:0] OPEN_TEXT  = 3'd1;
   localparam logic [2:0] OPEN_LINE  = 3'd2;
   localparam logic [2:0] OPEN_BLOCK = 3'd3;
   localparam logic [2:0] OPEN_QUOTE = 3'd4;
   localparam logic [2:0] OPEN_BACKQ = 3'd6;

   localparam logic [2:0] TT_TEXT  = 3'd0;
   localparam logic [2:0] TT_LINE  = 3'd1;
   localparam logic [2:0] TT_BLOCK = 3'd2;

   localparam logic [1:0] QC_NONE   = 2'd0;
   localparam logic [1:0] QC_SINGLE = 2'd1;
   localparam logic [1:0] QC_DOUBLE = 2'd2;
   localparam logic [1:0] QC_BACKQ  = 2'd3;

   localparam logic [15:0] U_HASH   = 16'h0023;
   localparam logic [15:0] U_DASH   = 16'h002D;
   localparam logic [15:0] U_SLASH  = 16'h002F;
   localparam logic [15:0] U_STAR   = 16'h002A;
   localparam logic [15:0] U_BSLASH = 16'h005C;
   localparam logic [15:0] U_BACKQ  = 16'h0060;
   localparam logic [15:0] U_DQUOTE = 16'h0022;
   localparam logic [15:0] U_SQUOTE = 16'h0027;
   localparam logic [15:0] U_LF     = 16'h000A;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] code_unit;
      logic [2:0]  open_type;
   } req_type;

   typedef struct packed {
      logic [15:0] span_start;
      logic [16:0] span_end;
      logic [2:0]  token_type;
      logic        open_left;
      logic        open_right;
      logic        is_final;
      logic        overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_UNIT,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type              kind;
      logic                     has_held;
      logic [15:0]              unit;
      logic [15:0]              next;
      logic [POSITION_BITS-1:0] pos;
      logic [POS_W-1:0]         end_pos;
      logic [2:0]               open_type;
      logic                     ovf;
   } op_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } rsp_wr_type;

   function automatic logic [15:0] to_start(input logic [POSITION_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[15:0];
   endfunction

   function automatic logic [16:0] to_end(input logic [POS_W-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[16:0];
   endfunction

   function automatic logic [1:0] quote_code(input logic [15:0] c);
      logic [1:0] q;
      q = QC_NONE;
      if (c == U_SQUOTE) q = QC_SINGLE;
      if (c == U_DQUOTE) q = QC_DOUBLE;
      if (c == U_BACKQ)  q = QC_BACKQ;
      return q;
   endfunction

endpackage

### src/sqltok_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, keeps the one-unit lookahead and the position
// counter, and turns each start, unit or end beat into an operation. Depends on sqltok_pkg.
module sqltok_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  sqltok_pkg::req_type req_item,
   output logic                req_full,
   input  logic                op_full,
   output logic                op_push,
   output sqltok_pkg::op_type  op_item
);
   import sqltok_pkg::*;

   logic [15:0]      held_unit_ff, held_unit_in;
   logic             held_valid_ff, held_valid_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic             overflow_ff, overflow_in;
   logic             accept;

   assign req_full = op_full;

   always_comb begin
      accept          = req_push && !op_full;
      held_unit_in    = held_unit_ff;
      held_valid_in   = held_valid_ff;
      position_in     = position_ff;
      overflow_in     = overflow_ff;
      op_push         = 1'b0;
      op_item.kind      = OP_UNIT;
      op_item.has_held  = held_valid_ff;
      op_item.unit      = held_unit_ff;
      op_item.next      = req_item.code_unit;
      op_item.pos       = POSITION_BITS'(position_ff - 1'b1);
      op_item.end_pos   = position_ff;
      op_item.open_type = req_item.open_type;
      op_item.ovf       = overflow_ff;
      if (accept) begin
         unique case (req_item.kind)
            KIND_START: begin
               op_item.kind  = OP_START;
               op_push       = 1'b1;
               held_unit_in  = '0;
               held_valid_in = 1'b0;
               position_in   = '0;
               overflow_in   = 1'b0;
            end
            KIND_UNIT: begin
               op_push = 1'b1;
               if (position_ff < POS_LIMIT) begin
                  position_in = position_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               held_unit_in  = req_item.code_unit;
               held_valid_in = 1'b1;
            end
            KIND_END: begin
               op_item.kind  = OP_END;
               op_item.next  = '0;
               op_push       = 1'b1;
               held_unit_in  = '0;
               held_valid_in = 1'b0;
               position_in   = '0;
               overflow_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_unit_ff  <= '0;
         held_valid_ff <= 1'b0;
         position_ff   <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         held_unit_ff  <= held_unit_in;
         held_valid_ff <= held_valid_in;
         position_ff   <= position_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

### src/sqltok_op_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of operations between front and back end.
// Depends on sqltok_pkg.
module sqltok_op_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sqltok_pkg::op_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output sqltok_pkg::op_type head
);
   import sqltok_pkg::*;

   op_type     mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/sqltok_back.sv
`timescale 1ns / 1ps
// Back end: comment, literal and escape tracking; opens and closes spans and
// emits up to two result beats per operation. Depends on sqltok_pkg.
module sqltok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_empty,
   input  sqltok_pkg::op_type     op_head,
   output logic                   op_pop,
   input  logic                   rsp_room,
   output sqltok_pkg::rsp_wr_type rsp_wr
);
   import sqltok_pkg::*;

   typedef struct packed {
      logic                     in_literal;
      logic                     in_line;
      logic                     in_block;
      logic                     escape;
      logic [1:0]               quote_char;
      logic                     token_active;
      logic [POSITION_BITS-1:0] token_begin;
      logic [2:0]               token_kind;
      logic                     token_left_open;
      logic                     skip_next;
   } back_state_type;

   back_state_type state_ff, state_in;

   function automatic rsp_type make_span(input back_state_type st,
                                         input logic [POS_W-1:0] e,
                                         input logic ro, input logic ovf);
      rsp_type r;
      r.span_start = to_start(st.token_begin);
      r.span_end   = to_end(e);
      r.token_type = st.token_kind;
      r.open_left  = st.token_left_open;
      r.open_right = ro;
      r.is_final   = 1'b0;
      r.overflowed = ovf;
      return r;
   endfunction

   always_comb begin
      back_state_type           s;
      rsp_type                  u, f;
      logic                     u_v, f_v;
      logic [15:0]              c, n;
      logic [POSITION_BITS-1:0] h;
      logic [POS_W-1:0]         h_ext, e;
      logic [1:0]               q;
      s      = state_ff;
      u      = '0;
      f      = '0;
      u_v    = 1'b0;
      f_v    = 1'b0;
      c      = op_head.unit;
      n      = op_head.next;
      h      = op_head.pos;
      h_ext  = POS_W'(h);
      e      = '0;
      q      = QC_NONE;
      op_pop = !op_empty && rsp_room;

      unique case (op_head.kind)
         OP_START: begin
            s = '0;
            if (op_head.open_type >= OPEN_TEXT && op_head.open_type <= OPEN_BACKQ) begin
               s.token_active    = 1'b1;
               s.token_kind      = op_head.open_type - OPEN_TEXT;
               s.token_left_open = 1'b1;
               if (op_head.open_type == OPEN_BLOCK) begin
                  s.in_block = 1'b1;
               end else if (op_head.open_type >= OPEN_QUOTE) begin
                  s.in_literal = 1'b1;
                  s.quote_char = 2'(op_head.open_type - OPEN_BLOCK);
               end
            end
         end
         OP_UNIT, OP_END: begin
            if (op_head.has_held && s.skip_next) begin
               s.skip_next = 1'b0;
            end else if (op_head.has_held) begin
               if (!s.token_active) begin
                  s.token_active    = 1'b1;
                  s.token_begin     = h;
                  s.token_kind      = TT_TEXT;
                  s.token_left_open = 1'b0;
               end
               if (!s.in_line && !s.in_block && !s.in_literal) begin
                  s.in_line = (c == U_HASH) || (c == U_DASH && n == U_DASH);
                  if (s.in_line) begin
                     u_v = h_ext > POS_W'(s.token_begin);
                     u   = make_span(s, h_ext, 1'b0, op_head.ovf);
                     s.token_active    = 1'b1;
                     s.token_begin     = h;
                     s.token_kind      = TT_LINE;
                     s.token_left_open = 1'b0;
                  end
               end
               if (!s.in_line && !s.in_block && !s.in_literal &&
                   c == U_SLASH && n == U_STAR) begin
                  s.in_block = 1'b1;
                  u_v = h_ext > POS_W'(s.token_begin);
                  u   = make_span(s, h_ext, 1'b0, op_head.ovf);
                  s.token_active    = 1'b1;
                  s.token_begin     = h;
                  s.token_kind      = TT_BLOCK;
                  s.token_left_open = 1'b0;
                  s.skip_next       = 1'b1;
               end
               if (s.in_block && !s.in_line && !s.in_literal &&
                   c == U_STAR && n == U_SLASH) begin
                  s.in_block = 1'b0;
                  if (s.token_active && s.token_kind == TT_BLOCK) begin
                     e = h_ext + POS_W'(2);
                     if (e > POS_LIMIT) begin
                        e = POS_LIMIT;
                     end
                     u_v = e > POS_W'(s.token_begin);
                     u   = make_span(s, e, 1'b0, op_head.ovf);
                     s.token_active = 1'b0;
                  end
                  s.skip_next = 1'b1;
               end
               q = quote_code(c);
               if (!s.escape && !s.in_line && !s.in_block && q != QC_NONE) begin
                  if (!s.in_literal || q == s.quote_char) begin
                     s.in_literal = !s.in_literal;
                     s.quote_char = q;
                     e = s.in_literal ? h_ext : h_ext + 1'b1;
                     if (s.token_active) begin
                        u_v = e > POS_W'(s.token_begin);
                        u   = make_span(s, e, 1'b0, op_head.ovf);
                        s.token_active = 1'b0;
                     end
                     if (s.in_literal) begin
                        s.token_active    = 1'b1;
                        s.token_begin     = h;
                        s.token_kind      = {1'b0, q} + 3'd2;
                        s.token_left_open = 1'b0;
                     end
                  end
               end
               if (c == U_LF && n != U_LF) begin
                  s.in_line = 1'b0;
                  if (s.token_active && s.token_kind == TT_LINE) begin
                     u_v = h_ext > POS_W'(s.token_begin);
                     u   = make_span(s, h_ext, 1'b0, op_head.ovf);
                     s.token_active = 1'b0;
                  end
               end
               s.escape = s.escape ? 1'b0 : (c == U_BSLASH);
            end
            if (op_head.kind == OP_END) begin
               if (s.token_active) begin
                  f_v = op_head.end_pos > POS_W'(s.token_begin);
                  f   = make_span(s, op_head.end_pos, s.in_block || s.in_literal,
                                  op_head.ovf);
               end
               if (f_v) begin
                  f.is_final = 1'b1;
               end else begin
                  u.is_final = 1'b1;
               end
               s = '0;
            end
         end
         default: begin
         end
      endcase

      state_in     = op_pop ? s : state_ff;
      rsp_wr.count = op_pop ? (2'(u_v) + 2'(f_v)) : 2'd0;
      rsp_wr.item0 = u_v ? u : f;
      rsp_wr.item1 = f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/sqltok_rsp_fifo.sv
`timescale 1ns / 1ps
// Four-entry result queue taking up to two beats per cycle, one out per cycle.
// Depends on sqltok_pkg.
module sqltok_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  sqltok_pkg::rsp_wr_type wr,
   output logic                   room,
   input  logic                   pop,
   output logic                   empty,
   output sqltok_pkg::rsp_type    head
);
   import sqltok_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_pop;

   assign empty = count_ff == 3'd0;
   assign room  = count_ff <= 3'd2;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff + wr.count;
      rd_ptr_in = rd_ptr_ff + 2'(do_pop);
      count_in  = count_ff + 3'(wr.count) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr.item0;
      end
      if (wr.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= wr.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/sql_comment_string_tokenizer_top.sv
`timescale 1ns / 1ps
// Top level of the SQL comment and string tokenizer: front end, op queue,
// back end and result queue. Depends on sqltok_pkg and all sqltok_ modules.
//
//  channel   direction  ports                          beat
//  request   in         req_push, req_full, req_item   one code unit, start or end
//  response  out        rsp_pop, rsp_empty, rsp_item   one span
//
// One request beat per cycle while req_full is low. The back end retires one op per cycle
// while the result queue has room for two beats; a span passes the op queue and then the
// result queue to reach the result ports, and a code unit is completed by the beat after it.
// An end beat yields up to two spans, other beats at most one.
// Synchronous reset empties both queues and clears the sentence state.
// req_full follows the two-entry op queue, so a stalled result side backs up
// into the request side after a few beats.
module sql_comment_string_tokenizer_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  sqltok_pkg::req_type req_item,
   output logic                req_full,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output sqltok_pkg::rsp_type rsp_item
);
   import sqltok_pkg::*;

   logic       op_push, op_full, op_pop, op_empty;
   op_type     op_in, op_head;
   logic       rsp_room;
   rsp_wr_type rsp_wr;

   sqltok_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .op_full  (op_full),
      .op_push  (op_push),
      .op_item  (op_in)
   );

   sqltok_op_fifo u_op_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_item (op_in),
      .full      (op_full),
      .pop       (op_pop),
      .empty     (op_empty),
      .head      (op_head)
   );

   sqltok_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_empty (op_empty),
      .op_head  (op_head),
      .op_pop   (op_pop),
      .rsp_room (rsp_room),
      .rsp_wr   (rsp_wr)
   );

   sqltok_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_wr),
      .room  (rsp_room),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .head  (rsp_item)
   );

   a_wr_room : assert property (@(posedge clock) disable iff (reset)
      rsp_wr.count != 2'd0 |-> rsp_room)
      else $error("result write without room");

   a_two_from_end : assert property (@(posedge clock) disable iff (reset)
      rsp_wr.count == 2'd2 |-> op_head.kind == OP_END)
      else $error("two spans from a non-end op");

   a_final_from_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_wr.count != 2'd0 && rsp_wr.item0.is_final) |-> op_head.kind == OP_END)
      else $error("final span from a non-end op");

   a_fill_source : assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(rsp_wr.count != 2'd0))
      else $error("result queue filled without a write");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for sql_comment_string_tokenizer_top: directed beats, a
// sentence against a stalled result side and random sentences, checked against
// a span predictor. Depends on sqltok_pkg and the tokenizer RTL.
module testbench;
   import sqltok_pkg::*;

   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [2:0] OPEN_DQUOTE  = 3'd5;
   localparam logic [2:0] OPEN_UNKNOWN = 3'd7;
   localparam logic [2:0] TT_DQUOTE    = 3'd4;
   localparam logic [15:0] U_LOWER_A   = 16'h0061;

   localparam int RANDOM_ITEMS    = 970;
   localparam int QUIET_TAIL      = 150;
   localparam int RSP_HOLD_CYCLES = 200;
   // ~1k beats; worst case with every gap and stall maxed is well under this
   localparam int CYCLE_LIMIT     = 1_000_000;

   localparam rsp_type NO_SPAN = '0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] code_unit;
      logic [2:0]  open_type;
      logic        typed;
      logic        has_span;
      rsp_type     span;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   logic    rsp_empty;
   rsp_type rsp_item;

   rsp_type pending_spans[$];
   rsp_type step_spans[$];
   rsp_type span_want;
   int      mismatches = 0;
   int      cycles = 0;
   int      counted_beats = 0;
   int      holds_asked = 0;
   int      holds_done = 0;
   int      gap_odds = 5;
   bit      idle_on = 1'b1;

   // sentence state of the predictor
   bit               lit, line_c, block_c, esc, tok_on, tok_left, held_ok, skip, ovf;
   logic [1:0]       qchar;
   logic [2:0]       tok_kind;
   logic [POS_W-1:0] tok_begin, pos;
   logic [15:0]      held;

   script_row_type directed_rows [28] = '{
      '{KIND_UNKNOWN, 16'hFFFF, OPEN_UNKNOWN, 1'b1, 1'b0, NO_SPAN},
      '{KIND_END,     16'h0000, OPEN_NONE,    1'b1, 1'b0, NO_SPAN},
      '{KIND_START,   16'h0000, OPEN_UNKNOWN, 1'b1, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_HASH,   OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_LF,     OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_DASH,   OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_DASH,   OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_END,     16'h0000, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_START,   16'h0000, OPEN_BLOCK,   1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_STAR,   OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_SLASH,  OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_SQUOTE, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_BSLASH, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_SQUOTE, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_SQUOTE, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_END,     16'h0000, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_START,   16'h0000, OPEN_LINE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_LOWER_A, OPEN_NONE,   1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_LF,     OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_DQUOTE, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_END,     16'h0000, OPEN_NONE,    1'b1, 1'b1,
        '{16'd2, 17'd3, TT_DQUOTE, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{KIND_START,   16'h0000, OPEN_BACKQ,   1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_BACKQ,  OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_SLASH,  OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    U_STAR,   OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_START,   16'h0000, OPEN_DQUOTE,  1'b0, 1'b0, NO_SPAN},
      '{KIND_UNIT,    16'hFFFF, OPEN_NONE,    1'b0, 1'b0, NO_SPAN},
      '{KIND_END,     16'h0000, OPEN_NONE,    1'b1, 1'b1,
        '{16'd0, 17'd1, TT_DQUOTE, 1'b1, 1'b1, 1'b1, 1'b0}}
   };

   sql_comment_string_tokenizer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // ---------------- span predictor ----------------

   function automatic void clear_sentence_state();
      lit = 1'b0; line_c = 1'b0; block_c = 1'b0; esc = 1'b0; qchar = QC_NONE;
      tok_on = 1'b0; tok_begin = '0; tok_kind = TT_TEXT; tok_left = 1'b0;
      held = '0; held_ok = 1'b0; skip = 1'b0; pos = '0; ovf = 1'b0;
   endfunction

   function automatic void open_span(input logic [POS_W-1:0] first, input logic [2:0] kind,
                                     input bit left);
      tok_on = 1'b1;
      tok_begin = first;
      tok_kind = kind;
      tok_left = left;
   endfunction

   function automatic void close_span(input logic [POS_W-1:0] stop, input bit right_open);
      rsp_type s;
      if (!tok_on) return;
      tok_on = 1'b0;
      if (stop <= tok_begin || step_spans.size() >= 2) return;
      s.span_start = tok_begin[15:0];
      s.span_end   = stop[16:0];
      s.token_type = tok_kind;
      s.open_left  = tok_left;
      s.open_right = right_open;
      s.is_final   = 1'b0;
      s.overflowed = ovf;
      step_spans.push_back(s);
   endfunction

   function automatic logic [1:0] quote_class(input logic [15:0] c);
      case (c)
         U_SQUOTE: return QC_SINGLE;
         U_DQUOTE: return QC_DOUBLE;
         U_BACKQ:  return QC_BACKQ;
         default:  return QC_NONE;
      endcase
   endfunction

   function automatic void scan_unit(input logic [15:0] c, input logic [15:0] n,
                                     input logic [POS_W-1:0] h);
      logic [1:0]     q;
      logic [POS_W:0] reach;
      if (!tok_on) open_span(h, TT_TEXT, 1'b0);
      if (!line_c && !block_c && !lit) begin
         line_c = (c == U_HASH) || (c == U_DASH && n == U_DASH);
         if (line_c) begin
            close_span(h, 1'b0);
            open_span(h, TT_LINE, 1'b0);
         end
      end
      if (!line_c && !block_c && !lit && c == U_SLASH && n == U_STAR) begin
         block_c = 1'b1;
         close_span(h, 1'b0);
         open_span(h, TT_BLOCK, 1'b0);
         skip = 1'b1;
      end
      if (block_c && !line_c && !lit && c == U_STAR && n == U_SLASH) begin
         block_c = 1'b0;
         reach = {1'b0, h} + 2'd2;
         if (reach > {1'b0, POS_LIMIT}) reach = {1'b0, POS_LIMIT};
         if (tok_on && tok_kind == TT_BLOCK) close_span(reach[POS_W-1:0], 1'b0);
         skip = 1'b1;
      end
      q = quote_class(c);
      if (!esc && !line_c && !block_c && q != QC_NONE && (!lit || q == qchar)) begin
         lit = !lit;
         qchar = q;
         close_span(lit ? h : h + 1'b1, 1'b0);
         if (lit) open_span(h, {1'b0, q} + 3'd2, 1'b0);
      end
      if (c == U_LF && n != U_LF) begin
         line_c = 1'b0;
         if (tok_on && tok_kind == TT_LINE) close_span(h, 1'b0);
      end
      esc = esc ? 1'b0 : (c == U_BSLASH);
   endfunction

   function automatic void flush_held(input logic [15:0] next_unit);
      if (!held_ok) return;
      if (skip) skip = 1'b0;
      else scan_unit(held, next_unit, pos - 1'b1);
   endfunction

   function automatic void tokenize_step(input req_type beat);
      rsp_type last;
      step_spans.delete();
      case (beat.kind)
         KIND_START: begin
            clear_sentence_state();
            if (beat.open_type >= OPEN_TEXT && beat.open_type <= OPEN_BACKQ) begin
               open_span('0, beat.open_type - 3'd1, 1'b1);
               if (beat.open_type == OPEN_BLOCK) begin
                  block_c = 1'b1;
               end else if (beat.open_type >= OPEN_QUOTE) begin
                  lit = 1'b1;
                  qchar = 2'(beat.open_type - OPEN_BLOCK);
               end
            end
         end
         KIND_UNIT: begin
            flush_held(beat.code_unit);
            if (pos < POS_LIMIT) pos = pos + 1'b1;
            else ovf = 1'b1;
            held = beat.code_unit;
            held_ok = 1'b1;
         end
         KIND_END: begin
            flush_held('0);
            close_span(pos, block_c || lit);
            if (step_spans.size() != 0) begin
               last = step_spans.pop_back();
               last.is_final = 1'b1;
               step_spans.push_back(last);
            end
            clear_sentence_state();
         end
         default: ;
      endcase
   endfunction

   // ---------------- stimulus ----------------

   function automatic req_type mk_beat(input logic [1:0] kind, input logic [15:0] cu,
                                       input logic [2:0] ot);
      req_type b;
      b.kind = kind;
      b.code_unit = cu;
      b.open_type = ot;
      return b;
   endfunction

   function automatic logic [15:0] pick_unit();
      case ($urandom_range(0, 15))
         0:       return U_HASH;
         1:       return U_DASH;
         2:       return U_SLASH;
         3:       return U_STAR;
         4:       return U_BSLASH;
         5:       return U_BACKQ;
         6:       return U_DQUOTE;
         7:       return U_SQUOTE;
         8:       return U_LF;
         9:       return U_LOWER_A;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_beat(input req_type beat, input logic typed = 1'b0,
                            input logic has_span = 1'b0, input rsp_type span = '0);
      if (idle_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= beat;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tokenize_step(beat);
      if (typed) begin
         if (has_span) pending_spans.push_back(span);
      end else begin
         foreach (step_spans[i]) pending_spans.push_back(step_spans[i]);
      end
      if (beat.kind != KIND_UNKNOWN) counted_beats++;
   endtask

   task automatic send_unit(input logic [15:0] cu);
      send_beat(mk_beat(KIND_UNIT, cu, 3'($urandom_range(0, 7))));
   endtask

   task automatic send_start(input logic [2:0] ot);
      send_beat(mk_beat(KIND_START, 16'($urandom_range(0, 65535)), ot));
   endtask

   task automatic send_end();
      send_beat(mk_beat(KIND_END, 16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7))));
   endtask

   task automatic wait_spans_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_spans.size() != 0);
   endtask

   initial begin
      int random_goal;
      int shape;
      int len;
      clear_sentence_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(mk_beat(directed_rows[i].kind, directed_rows[i].code_unit,
                           directed_rows[i].open_type),
                   directed_rows[i].typed, directed_rows[i].has_span, directed_rows[i].span);
      wait_spans_drained();

      // result side stalls while the request side keeps pushing
      holds_asked++;
      send_start(OPEN_NONE);
      repeat (48) send_unit(pick_unit());
      send_end();
      wait_spans_drained();

      random_goal = counted_beats + RANDOM_ITEMS;
      while (counted_beats < random_goal) begin
         if (random_goal - counted_beats < QUIET_TAIL) idle_on = 1'b0;
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
         shape = $urandom_range(0, 15);
         if (shape != 0) send_start(3'($urandom_range(0, 7)));
         len = (shape == 2) ? $urandom_range(25, 60) : $urandom_range(0, 16);
         repeat (len) begin
            if ($urandom_range(0, 31) == 0)
               send_beat(mk_beat(KIND_UNKNOWN, 16'($urandom_range(0, 65535)),
                                 3'($urandom_range(0, 7))));
            send_unit(pick_unit());
         end
         if (shape != 1) send_end();
      end

      wait_spans_drained();
      repeat (12) @(posedge clock);
      if (mismatches == 0 && pending_spans.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ---------------- result side ----------------

   initial begin
      forever begin
         if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            rsp_pop <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_spans.size() == 0) begin
            $error("span beat with nothing expected: start %0d end %0d type %0d",
                   rsp_item.span_start, rsp_item.span_end, rsp_item.token_type);
            mismatches = mismatches + 1;
         end else begin
            span_want = pending_spans.pop_front();
            check_field("span_start", 17'(span_want.span_start), 17'(rsp_item.span_start));
            check_field("span_end", span_want.span_end, rsp_item.span_end);
            check_field("token_type", 17'(span_want.token_type), 17'(rsp_item.token_type));
            check_field("open_left", 17'(span_want.open_left), 17'(rsp_item.open_left));
            check_field("open_right", 17'(span_want.open_right), 17'(rsp_item.open_right));
            check_field("is_final", 17'(span_want.is_final), 17'(rsp_item.is_final));
            check_field("overflowed", 17'(span_want.overflowed), 17'(rsp_item.overflowed));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
